### hw/rtl/ray_box_intersection_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ray/box intersection unit
// Concurrent checks sampled on the rising edge of clock.
// ---------------------------------------------------------------------------
`ifndef RAY_BOX_INTERSECTION_UNIT_DEFINES_SVH
`define RAY_BOX_INTERSECTION_UNIT_DEFINES_SVH

// check that is masked while reset is high
`define RBI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that is also evaluated around reset
`define RBI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hw/rtl/rbi_pkg.sv
// ---------------------------------------------------------------------------
// rbi_pkg
// Shared widths, codes and types of the ray/box intersection unit.
// ---------------------------------------------------------------------------
`default_nettype none

package rbi_pkg;

   // number format: signed Q16.16
   localparam int CoordWidth = 32;
   localparam int FracBits   = 16;
   localparam int NumAxes    = 3;

   localparam int DistWidth  = CoordWidth - 1;
   localparam int NumWidth   = CoordWidth + 1;
   localparam int RemWidth   = CoordWidth;
   localparam int DivSteps   = CoordWidth - 1;
   localparam int LaneDepth  = DivSteps + 1;
   localparam int InitShift  = CoordWidth - 1 - FracBits;
   localparam int ProdWidth  = 2 * CoordWidth;
   localparam int PosWidth   = 2 * CoordWidth + 1;

   // stream packing
   localparam int ModeWidth    = 2;
   localparam int CodeWidth    = 2;
   localparam int ReqBits      = 2 * NumAxes * CoordWidth + DistWidth + ModeWidth;
   localparam int ReqDataWidth = ((ReqBits + 7) / 8) * 8;
   localparam int RspBits      = CodeWidth + DistWidth;
   localparam int RspDataWidth = ((RspBits + 7) / 8) * 8;

   // register map
   localparam int RegIdxWidth = 3;
   localparam int AddrWidth   = RegIdxWidth + 2;
   localparam logic [RegIdxWidth-1:0] RegBoxMinX = 3'd0;
   localparam logic [RegIdxWidth-1:0] RegBoxMinY = 3'd1;
   localparam logic [RegIdxWidth-1:0] RegBoxMinZ = 3'd2;
   localparam logic [RegIdxWidth-1:0] RegBoxMaxX = 3'd3;
   localparam logic [RegIdxWidth-1:0] RegBoxMaxY = 3'd4;
   localparam logic [RegIdxWidth-1:0] RegBoxMaxZ = 3'd5;

   // side modes
   localparam logic [ModeWidth-1:0] ModeEither = 2'b00;
   localparam logic [ModeWidth-1:0] ModeInside = 2'b01;

   // hit codes
   localparam logic [CodeWidth-1:0] HitNone    = 2'd0;
   localparam logic [CodeWidth-1:0] HitOutside = 2'd1;
   localparam logic [CodeWidth-1:0] HitInside  = 2'd2;

   localparam logic [DistWidth-1:0] DistMax = {DistWidth{1'b1}};

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic [DistWidth-1:0]         dist_type;

   typedef struct packed {
      logic [NumAxes-1:0][CoordWidth-1:0] origin;
      logic [NumAxes-1:0][CoordWidth-1:0] dir;
      dist_type                           max_dist;
   } ray_type;

   typedef struct packed {
      logic                 act;
      logic [CodeWidth-1:0] code;
      dist_type             t;
   } lane_res_type;

endpackage

`default_nettype wire

### hw/rtl/rbi_lane.sv
// ---------------------------------------------------------------------------
// rbi_lane
// One axis: face choice and a pipelined restoring divider for the face distance.
// ---------------------------------------------------------------------------
`default_nettype none

module rbi_lane import rbi_pkg::*; (
   input  wire logic         clock,
   input  wire logic         en,
   input  wire coord_type    origin,
   input  wire coord_type    dir,
   input  wire coord_type    box_lo,
   input  wire coord_type    box_hi,
   input  wire logic         allow_out,
   input  wire logic         allow_in,
   output lane_res_type      result
);

   logic [NumWidth-1:0]  num_ff  [LaneDepth];
   logic [NumWidth-1:0]  num_in  [LaneDepth];
   logic [RemWidth-1:0]  den_ff  [LaneDepth];
   logic [RemWidth-1:0]  den_in  [LaneDepth];
   logic [RemWidth-1:0]  rem_ff  [LaneDepth];
   logic [RemWidth-1:0]  rem_in  [LaneDepth];
   logic [DistWidth-1:0] q_ff    [LaneDepth];
   logic [DistWidth-1:0] q_in    [LaneDepth];
   logic                 ovf_ff  [LaneDepth];
   logic                 ovf_in  [LaneDepth];
   logic [CodeWidth-1:0] code_ff [LaneDepth];
   logic [CodeWidth-1:0] code_in [LaneDepth];
   logic                 act_ff  [LaneDepth];
   logic                 act_in  [LaneDepth];

   // face choice and operands of the first stage
   logic [NumWidth-1:0]  front_num;
   logic [CodeWidth-1:0] front_code;
   logic                 front_act;

   always_comb begin
      front_num  = '0;
      front_code = HitNone;
      front_act  = 1'b0;
      if (dir != '0) begin
         if (!dir[CoordWidth-1]) begin
            if ((origin <= box_lo) && allow_out) begin
               front_num  = {box_lo[CoordWidth-1], box_lo} - {origin[CoordWidth-1], origin};
               front_code = HitOutside;
               front_act  = 1'b1;
            end else if ((origin <= box_hi) && allow_in) begin
               front_num  = {box_hi[CoordWidth-1], box_hi} - {origin[CoordWidth-1], origin};
               front_code = HitInside;
               front_act  = 1'b1;
            end
         end else begin
            if ((box_hi <= origin) && allow_out) begin
               front_num  = {origin[CoordWidth-1], origin} - {box_hi[CoordWidth-1], box_hi};
               front_code = HitOutside;
               front_act  = 1'b1;
            end else if ((box_lo <= origin) && allow_in) begin
               front_num  = {origin[CoordWidth-1], origin} - {box_lo[CoordWidth-1], box_lo};
               front_code = HitInside;
               front_act  = 1'b1;
            end
         end
      end
   end

   // divider stages, one quotient bit each
   always_comb begin
      logic [NumWidth+FracBits-1:0] dvd;
      logic [RemWidth+1:0]          diff;
      logic [RemWidth:0]            shifted;
      num_in[0]  = front_num;
      den_in[0]  = dir[CoordWidth-1] ? RemWidth'(~dir + 1'b1) : RemWidth'(dir);
      rem_in[0]  = RemWidth'(front_num >> InitShift);
      q_in[0]    = '0;
      ovf_in[0]  = 1'b0;
      code_in[0] = front_code;
      act_in[0]  = front_act;
      for (int s = 1; s < LaneDepth; s++) begin
         dvd       = {num_ff[s-1], {FracBits{1'b0}}};
         shifted   = {rem_ff[s-1], dvd[DivSteps-s]};
         diff      = {1'b0, shifted} - {2'b00, den_ff[s-1]};
         num_in[s]  = num_ff[s-1];
         den_in[s]  = den_ff[s-1];
         code_in[s] = code_ff[s-1];
         act_in[s]  = act_ff[s-1];
         ovf_in[s]  = (s == 1) ? (rem_ff[0] >= den_ff[0]) : ovf_ff[s-1];
         if (!diff[RemWidth+1]) begin
            rem_in[s] = diff[RemWidth-1:0];
            q_in[s]   = {q_ff[s-1][DistWidth-2:0], 1'b1};
         end else begin
            rem_in[s] = shifted[RemWidth-1:0];
            q_in[s]   = {q_ff[s-1][DistWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < LaneDepth; s++) begin
            num_ff[s]  <= num_in[s];
            den_ff[s]  <= den_in[s];
            rem_ff[s]  <= rem_in[s];
            q_ff[s]    <= q_in[s];
            ovf_ff[s]  <= ovf_in[s];
            code_ff[s] <= code_in[s];
            act_ff[s]  <= act_in[s];
         end
      end
   end

   // saturate quotients at or above the largest value
   assign result.act  = act_ff[LaneDepth-1];
   assign result.code = code_ff[LaneDepth-1];
   assign result.t    = ovf_ff[LaneDepth-1] ? DistMax : q_ff[LaneDepth-1];

endmodule

`default_nettype wire

### hw/rtl/rbi_merge.sv
// ---------------------------------------------------------------------------
// rbi_merge
// Hit point checks on the other two axes and nearest-candidate selection.
// ---------------------------------------------------------------------------
`default_nettype none

module rbi_merge import rbi_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire lane_res_type         lane_res [NumAxes],
   input  wire ray_type              ray,
   input  wire coord_type            box_lo   [NumAxes],
   input  wire coord_type            box_hi   [NumAxes],
   output logic [CodeWidth-1:0]      hit_code,
   output dist_type                  hit_dist
);

   // stage A: products t * dir on the other axes
   logic signed [ProdWidth-1:0] prod_ff [NumAxes][2];
   lane_res_type                resa_ff [NumAxes];
   coord_type                   orig_ff [NumAxes];
   dist_type                    maxa_ff;

   always_ff @(posedge clock) begin
      int b;
      if (en) begin
         for (int a = 0; a < NumAxes; a++) begin
            for (int j = 0; j < 2; j++) begin
               b = (a + j + 1 >= NumAxes) ? a + j + 1 - NumAxes : a + j + 1;
               prod_ff[a][j] <= $signed({1'b0, lane_res[a].t}) * $signed(ray.dir[b]);
            end
            resa_ff[a] <= lane_res[a];
            orig_ff[a] <= $signed(ray.origin[a]);
         end
         maxa_ff <= ray.max_dist;
      end
   end

   // stage B: point inside the box on both other axes
   logic                 ok_ff   [NumAxes];
   dist_type             tb_ff   [NumAxes];
   logic [CodeWidth-1:0] codeb_ff[NumAxes];
   dist_type             maxb_ff;

   always_ff @(posedge clock) begin
      int b;
      logic signed [PosWidth-1:0] pos;
      logic in_box;
      if (en) begin
         for (int a = 0; a < NumAxes; a++) begin
            in_box = 1'b1;
            for (int j = 0; j < 2; j++) begin
               b = (a + j + 1 >= NumAxes) ? a + j + 1 - NumAxes : a + j + 1;
               pos = PosWidth'(prod_ff[a][j] >>> FracBits) + PosWidth'(orig_ff[b]);
               if ((pos < PosWidth'(box_lo[b])) || (pos > PosWidth'(box_hi[b])))
                  in_box = 1'b0;
            end
            ok_ff[a]    <= resa_ff[a].act && in_box;
            tb_ff[a]    <= resa_ff[a].t;
            codeb_ff[a] <= resa_ff[a].code;
         end
         maxb_ff <= maxa_ff;
      end
   end

   // nearest candidate below the limit, lower axis wins ties
   always_comb begin
      hit_dist = maxb_ff;
      hit_code = HitNone;
      for (int a = 0; a < NumAxes; a++) begin
         if (ok_ff[a] && (tb_ff[a] < hit_dist)) begin
            hit_dist = tb_ff[a];
            hit_code = codeb_ff[a];
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ray_box_intersection_unit.sv
// ---------------------------------------------------------------------------
// ray_box_intersection_unit
// Slab test of a ray against a configured axis-aligned box, Q16.16 fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   The box bounds sit in six registers on the csr_ APB port (min x,y,z at
//   0x00..0x08, max x,y,z at 0x0C..0x14); write them while the unit is idle.
//   Each req_ transaction carries one ray; each rsp_ transaction returns one
//   hit code and distance, in request order.
//   Three axis lanes compute face distances in parallel; each lane holds a
//   restoring divider pipelined at one quotient bit per stage (31 stages).
//   The merge stages multiply, check the hit point and pick the nearest.
//   A request passes the lane registers, merge stages A and B and the output register.
//   Throughput: one ray per cycle while a waiting response does not stall the pipeline.
//   Stall: while a response waits for rsp_tready the whole pipeline holds
//   and req_tready is low; bubbles keep moving otherwise.
//   Reset clears the box registers to zero and empties the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ray_box_intersection_unit_defines.svh"

module ray_box_intersection_unit import rbi_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance, side_mode
   input  wire logic [ReqDataWidth-1:0]  req_tdata,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // hit_code, hit_distance
   output logic [RspDataWidth-1:0]       rsp_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [AddrWidth-1:0]     csr_paddr,
   input  wire logic [CoordWidth-1:0]    csr_pwdata,
   output logic [CoordWidth-1:0]         csr_prdata,
   output logic                          csr_pready
);

   localparam int ValidDepth = LaneDepth + 2;

   // register file
   coord_type box_lo_ff [NumAxes];
   coord_type box_hi_ff [NumAxes];
   logic [RegIdxWidth-1:0] csr_idx;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[AddrWidth-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumAxes; i++) begin
            box_lo_ff[i] <= '0;
            box_hi_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         unique case (csr_idx)
            RegBoxMinX: box_lo_ff[0] <= csr_pwdata;
            RegBoxMinY: box_lo_ff[1] <= csr_pwdata;
            RegBoxMinZ: box_lo_ff[2] <= csr_pwdata;
            RegBoxMaxX: box_hi_ff[0] <= csr_pwdata;
            RegBoxMaxY: box_hi_ff[1] <= csr_pwdata;
            RegBoxMaxZ: box_hi_ff[2] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         RegBoxMinX: csr_prdata = box_lo_ff[0];
         RegBoxMinY: csr_prdata = box_lo_ff[1];
         RegBoxMinZ: csr_prdata = box_lo_ff[2];
         RegBoxMaxX: csr_prdata = box_hi_ff[0];
         RegBoxMaxY: csr_prdata = box_hi_ff[1];
         RegBoxMaxZ: csr_prdata = box_hi_ff[2];
         default:    csr_prdata = '0;
      endcase
   end

   // pipeline advance
   logic en;
   logic rsp_valid_ff;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // unpack request
   ray_type              ray_in;
   logic [ModeWidth-1:0] side_mode;
   logic                 allow_out;
   logic                 allow_in;

   always_comb begin
      for (int i = 0; i < NumAxes; i++) begin
         ray_in.origin[i] = req_tdata[i*CoordWidth +: CoordWidth];
         ray_in.dir[i]    = req_tdata[(NumAxes+i)*CoordWidth +: CoordWidth];
      end
      ray_in.max_dist = req_tdata[2*NumAxes*CoordWidth +: DistWidth];
      side_mode       = req_tdata[2*NumAxes*CoordWidth+DistWidth +: ModeWidth];
   end

   assign allow_out = (side_mode != ModeInside);
   assign allow_in  = (side_mode == ModeEither) || (side_mode == ModeInside);

   // axis lanes
   lane_res_type lane_res [NumAxes];

   for (genvar g = 0; g < NumAxes; g++) begin : g_lane
      rbi_lane u_lane (
         .clock     (clock),
         .en        (en),
         .origin    ($signed(ray_in.origin[g])),
         .dir       ($signed(ray_in.dir[g])),
         .box_lo    (box_lo_ff[g]),
         .box_hi    (box_hi_ff[g]),
         .allow_out (allow_out),
         .allow_in  (allow_in),
         .result    (lane_res[g])
      );
   end

   // ray delay line alongside the lanes
   ray_type ray_ff [LaneDepth];

   always_ff @(posedge clock) begin
      if (en) begin
         ray_ff[0] <= ray_in;
         for (int s = 1; s < LaneDepth; s++)
            ray_ff[s] <= ray_ff[s-1];
      end
   end

   // valid tracking
   logic valid_ff [ValidDepth];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < ValidDepth; s++)
            valid_ff[s] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= req_tvalid;
         for (int s = 1; s < ValidDepth; s++)
            valid_ff[s] <= valid_ff[s-1];
      end
   end

   // merge
   logic [CodeWidth-1:0] merge_code;
   dist_type             merge_dist;

   rbi_merge u_merge (
      .clock    (clock),
      .en       (en),
      .lane_res (lane_res),
      .ray      (ray_ff[LaneDepth-1]),
      .box_lo   (box_lo_ff),
      .box_hi   (box_hi_ff),
      .hit_code (merge_code),
      .hit_dist (merge_dist)
   );

   // output register
   logic [CodeWidth-1:0] rsp_code_ff;
   dist_type             rsp_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= valid_ff[ValidDepth-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_code_ff <= merge_code;
         rsp_dist_ff <= merge_dist;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-RspBits){1'b0}}, rsp_dist_ff, rsp_code_ff};

   // checks
   `RBI_ASSERT_ALWAYS(a_reset_empties, $past(reset) |-> !rsp_tvalid, "response after reset")
   `RBI_ASSERT(a_code_legal, rsp_tvalid |-> (rsp_code_ff <= HitInside), "illegal hit code")
   `RBI_ASSERT(a_accept_enters, (req_tvalid && req_tready) |=> valid_ff[0], "ray lost at entry")

endmodule

`default_nettype wire

### verif/ray_box_intersection_unit_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_box_intersection_unit_checker
// Watches the request, response and register ports of the ray/box unit. It
// keeps its own copy of the box, predicts the hit code and distance of each
// accepted ray, and compares every response with the oldest prediction.
// ---------------------------------------------------------------------------
module ray_box_intersection_unit_checker import rbi_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [ReqDataWidth-1:0] req_tdata,
   input  wire logic                    req_tvalid,
   input  wire logic                    req_tready,
   input  wire logic [RspDataWidth-1:0] rsp_tdata,
   input  wire logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [AddrWidth-1:0]    csr_paddr,
   input  wire logic [CoordWidth-1:0]   csr_pwdata,
   input  wire logic                    csr_pready,
   output int                           pending,
   output int                           fail_count
);

   typedef struct packed {
      logic [CodeWidth-1:0] code;
      dist_type             distance;
   } hit_type;

   localparam logic [63:0] SatLimit = (64'd1 << (CoordWidth - 1)) - 64'd1;

   coord_type box_min [NumAxes];
   coord_type box_max [NumAxes];
   hit_type   hit_queue [$];

   // is origin + t*dir within the box on axis b (inclusive bounds)
   function automatic bit point_in_slab(logic [63:0] t, coord_type org, coord_type dir,
                                        coord_type lo, coord_type hi);
      logic signed [127:0] tt;
      logic signed [127:0] dd;
      logic signed [127:0] pos;
      tt  = {64'd0, t};
      dd  = dir;
      pos = ((tt * dd) >>> FracBits) + 128'(signed'(org));
      return (pos >= 128'(signed'(lo))) && (pos <= 128'(signed'(hi)));
   endfunction

   // slab test: nearest allowed face hit below the limit, ties to lower axis
   function automatic hit_type predict_hit(logic [ReqDataWidth-1:0] data);
      coord_type           org [NumAxes];
      coord_type           dir [NumAxes];
      logic [ModeWidth-1:0] mode;
      logic signed [63:0]  p, d, lo, hi, num, den;
      logic [63:0]         q;
      logic [CodeWidth-1:0] c;
      bit                  allow_out, allow_in, found;
      int                  b1, b2;
      hit_type             res;
      for (int a = 0; a < NumAxes; a++) begin
         org[a] = data[CoordWidth*a +: CoordWidth];
         dir[a] = data[CoordWidth*(NumAxes+a) +: CoordWidth];
      end
      res.distance = data[2*NumAxes*CoordWidth +: DistWidth];
      mode         = data[2*NumAxes*CoordWidth+DistWidth +: ModeWidth];
      res.code     = HitNone;
      allow_out    = (mode != ModeInside);
      allow_in     = (mode == ModeEither) || (mode == ModeInside);
      for (int a = 0; a < NumAxes; a++) begin
         p  = org[a];
         d  = dir[a];
         lo = box_min[a];
         hi = box_max[a];
         found = 1'b1;
         num = 0;
         c = HitNone;
         if (d == 0) begin
            found = 1'b0;
         end else if (d > 0) begin
            if (p <= lo && allow_out) begin
               num = lo - p; c = HitOutside;
            end else if (p <= hi && allow_in) begin
               num = hi - p; c = HitInside;
            end else found = 1'b0;
         end else begin
            if (hi <= p && allow_out) begin
               num = p - hi; c = HitOutside;
            end else if (lo <= p && allow_in) begin
               num = p - lo; c = HitInside;
            end else found = 1'b0;
         end
         if (found) begin
            den = (d < 0) ? -d : d;
            q   = (64'(num) << FracBits) / 64'(den);
            if (q > SatLimit) q = SatLimit;
            b1 = (a + 1) % NumAxes;
            b2 = (a + 2) % NumAxes;
            if (q < 64'(res.distance) &&
                point_in_slab(q, org[b1], dir[b1], box_min[b1], box_max[b1]) &&
                point_in_slab(q, org[b2], dir[b2], box_min[b2], box_max[b2])) begin
               res.distance = q[DistWidth-1:0];
               res.code     = c;
            end
         end
      end
      return res;
   endfunction

   assign pending = hit_queue.size();

   always @(posedge clock) begin
      hit_type want;
      int      idx;
      if (reset) begin
         for (int a = 0; a < NumAxes; a++) begin
            box_min[a] <= '0;
            box_max[a] <= '0;
         end
         hit_queue.delete();
         fail_count = 0;
      end else begin
         // response transaction against oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (hit_queue.size() == 0) begin
               $display("%0t: unexpected response code=%0d dist=%h", $time,
                        rsp_tdata[CodeWidth-1:0], rsp_tdata[CodeWidth +: DistWidth]);
               fail_count++;
            end else begin
               want = hit_queue.pop_front();
               if (rsp_tdata[CodeWidth-1:0] != want.code) begin
                  $display("%0t: hit_code expected %0d actual %0d", $time,
                           want.code, rsp_tdata[CodeWidth-1:0]);
                  fail_count++;
               end
               if (rsp_tdata[CodeWidth +: DistWidth] != want.distance) begin
                  $display("%0t: hit_distance expected %h actual %h", $time,
                           want.distance, rsp_tdata[CodeWidth +: DistWidth]);
                  fail_count++;
               end
            end
         end
         // request transaction
         if (req_tvalid && req_tready) hit_queue.push_back(predict_hit(req_tdata));
         // register write; indexes past the last register are ignored
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            idx = csr_paddr >> 2;
            if (idx < NumAxes) box_min[idx] <= csr_pwdata;
            else if (idx < 2 * NumAxes) box_max[idx - NumAxes] <= csr_pwdata;
         end
      end
   end

endmodule

### verif/ray_box_intersection_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_box_intersection_unit_tb
// Drives rays into the ray/box unit under several box settings and flow
// control patterns: random rays against the reset box, a directed set of
// corner cases, then mostly targeted random rays. The checker module
// predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module ray_box_intersection_unit_tb;
   import rbi_pkg::*;

   localparam logic [ModeWidth-1:0] ModeOutside  = 2'b11;
   localparam logic [ModeWidth-1:0] ModeMinusTwo = 2'b10;
   localparam int  Latency    = 40;
   localparam int  CycleLimit = 1000000;
   localparam int  Unit       = 65536;

   typedef logic [NumAxes-1:0][CoordWidth-1:0] vec_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [AddrWidth-1:0]    csr_paddr = '0;
   logic [CoordWidth-1:0]   csr_pwdata = '0;
   logic [CoordWidth-1:0]   csr_prdata;
   logic                    csr_pready;
   int                      pending, fail_count;
   int                      send_idle_pct = 0;
   int                      recv_stall_pct = 0;
   int                      hold_left = 0;
   int                      cycles = 0;
   longint                  bmin [NumAxes];
   longint                  bmax [NumAxes];

   ray_box_intersection_unit i_dut (.*);

   ray_box_intersection_unit_checker i_checker (
      .clock, .reset, .req_tdata, .req_tvalid, .req_tready, .rsp_tdata, .rsp_tvalid,
      .rsp_tready, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_pready, .pending, .fail_count);

   always #5 clock = ~clock;

   // timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("FAIL ray_box_intersection_unit");
         $finish;
      end
   end

   // receiver: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // one ray transaction, then a random gap
   task automatic send_ray(vec_type org, vec_type dir, dist_type limit,
                           logic [ModeWidth-1:0] mode);
      int gap;
      req_tdata  <= ReqDataWidth'({mode, limit, dir, org});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (Latency) @(posedge clock);
   endtask

   task automatic csr_write(int idx, longint value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= AddrWidth'(idx * 4);
      csr_pwdata  <= CoordWidth'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_box(longint lo [NumAxes], longint hi [NumAxes]);
      wait_idle();
      for (int a = 0; a < NumAxes; a++) begin
         bmin[a] = lo[a];
         bmax[a] = hi[a];
         csr_write(RegBoxMinX + a, lo[a]);
         csr_write(RegBoxMaxX + a, hi[a]);
      end
   endtask

   function automatic longint rnd_coord(int span_units);
      return longint'($urandom_range(2 * span_units * Unit)) - longint'(span_units) * Unit;
   endfunction

   // mostly rays aimed at a point of the box, some pure noise
   task automatic send_random_ray();
      vec_type              org, dir;
      dist_type             limit;
      logic [ModeWidth-1:0] mode;
      longint               lo, span, tgt, o, delta;
      int                   k;
      if ($urandom_range(99) < 15) begin
         for (int a = 0; a < NumAxes; a++) begin
            org[a] = $urandom;
            dir[a] = $urandom;
         end
         limit = DistWidth'($urandom);
         mode  = ModeWidth'($urandom);
      end else begin
         k = $urandom_range(6);
         for (int a = 0; a < NumAxes; a++) begin
            lo   = (bmin[a] <= bmax[a]) ? bmin[a] : bmax[a];
            span = (bmin[a] <= bmax[a]) ? bmax[a] - bmin[a] : bmin[a] - bmax[a];
            tgt  = lo + longint'($urandom) % (span + 1);
            o    = tgt + rnd_coord($urandom_range(1) ? 8 : 300);
            delta = tgt - o;
            org[a] = CoordWidth'(o);
            dir[a] = (k < 3) ? CoordWidth'(delta >>> k) : CoordWidth'(delta <<< (k - 3));
            if ($urandom_range(99) < 12) dir[a] = '0;
         end
         case ($urandom_range(3))
            0: mode = ModeOutside;
            1: mode = ModeEither;
            2: mode = ModeInside;
            default: mode = ModeMinusTwo;
         endcase
         case ($urandom_range(9))
            0, 1, 2, 3, 4: limit = DistMax;
            5, 6, 7: limit = DistWidth'($urandom);
            default: limit = DistWidth'($urandom_range(1 << 19));
         endcase
      end
      send_ray(org, dir, limit, mode);
   endtask

   function automatic vec_type vec(longint x, longint y, longint z);
      vec_type v;
      v[0] = CoordWidth'(x);
      v[1] = CoordWidth'(y);
      v[2] = CoordWidth'(z);
      return v;
   endfunction

   initial begin
      longint lo [NumAxes];
      longint hi [NumAxes];
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int a = 0; a < NumAxes; a++) begin
         bmin[a] = 0;
         bmax[a] = 0;
      end

      // rays against the reset box (a single point)
      repeat (40) send_random_ray();

      // directed: unit box [-1, 1] on every axis
      lo = '{-Unit, -Unit, -Unit};
      hi = '{Unit, Unit, Unit};
      set_box(lo, hi);
      send_ray(vec(-5 * Unit, 0, 0), vec(Unit, 0, 0), DistMax, ModeEither);
      send_ray(vec(5 * Unit, 0, 0), vec(-Unit, 0, 0), DistMax, ModeOutside);
      send_ray(vec(0, 0, 0), vec(0, Unit, 0), DistMax, ModeInside);
      send_ray(vec(0, 0, 0), vec(0, 0, -Unit), DistMax, ModeEither);
      send_ray(vec(0, 0, 0), vec(Unit, 0, 0), DistMax, ModeOutside);
      send_ray(vec(0, 0, 0), vec(Unit, 0, 0), DistMax, ModeMinusTwo);
      send_ray(vec(-5 * Unit, 0, 0), vec(Unit, 0, 0), DistMax, ModeMinusTwo);
      send_ray(vec(-5 * Unit, 0, 0), vec(Unit, 0, 0), DistMax, ModeInside);
      send_ray(vec(0, 0, 0), vec(0, 0, 0), DistMax, ModeEither);
      // tie between x and y faces at the box corner edge
      send_ray(vec(-2 * Unit, -2 * Unit, 0), vec(Unit, Unit, 0), DistMax, ModeEither);
      // distance equal to the limit, and a zero limit
      send_ray(vec(-5 * Unit, 0, 0), vec(Unit, 0, 0), 4 * Unit, ModeEither);
      send_ray(vec(-5 * Unit, 0, 0), vec(Unit, 0, 0), 4 * Unit + 1, ModeEither);
      send_ray(vec(-5 * Unit, 0, 0), vec(Unit, 0, 0), '0, ModeEither);
      // tiny direction: quotient saturates
      send_ray(vec(-2000 * Unit, 0, 0), vec(1, 0, 0), DistMax, ModeEither);
      // miss in the other axes
      send_ray(vec(-5 * Unit, 3 * Unit, 0), vec(Unit, 0, 0), DistMax, ModeEither);
      // field extremes
      send_ray(vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
               vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), DistMax, ModeEither);
      send_ray(vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
               vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), DistMax, ModeOutside);
      send_ray(vec(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF),
               vec(32'h8000_0000, 32'hFFFF_FFFF, 1), DistMax, ModeInside);
      send_ray(vec(Unit + 1, 0, 0), vec(-1, 1, 0), DistMax, ModeEither);

      // ignored register index, then the random phases
      wait_idle();
      csr_write(2 * NumAxes, 32'h1234_5678);
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            1: begin
               lo = '{-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000};
               hi = '{64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF};
            end
            3: begin
               lo = '{2 * Unit, -Unit, Unit};
               hi = '{-Unit, Unit, -3 * Unit};
            end
            5: begin
               lo = '{64'sh7FFF_FFFF, -64'sh8000_0000, 0};
               hi = '{64'sh7FFF_FFFF, -64'sh8000_0000, 0};
            end
            default: begin
               for (int a = 0; a < NumAxes; a++) begin
                  lo[a] = rnd_coord(200);
                  hi[a] = lo[a] + longint'($urandom_range(100 * Unit));
               end
            end
         endcase
         set_box(lo, hi);
         send_idle_pct  = (ph % 4 == 1) ? 80 : (ph % 4 == 3) ? 19 : 0;
         recv_stall_pct = (ph % 4 == 2) ? 80 : (ph % 4 == 3) ? 19 : 0;
         for (int n = 0; n < 185; n++) begin
            // long receiver hold-off while rays keep coming
            if (ph == 2 && n == 20) hold_left = 300;
            // sender pause until every result is back
            if (ph == 4 && n == 90) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
            send_random_ray();
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (Latency) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS ray_box_intersection_unit");
      end else begin
         $display("FAIL ray_box_intersection_unit");
      end
      $finish;
   end

endmodule
